[rtl/sas_pkg.sv]
`default_nettype none

package sas_pkg;

    // Axis modes
    localparam logic [2:0] MODE_IDLE  = 3'd0;
    localparam logic [2:0] MODE_RUN   = 3'd1;
    localparam logic [2:0] MODE_HOME  = 3'd2;
    localparam logic [2:0] MODE_JOG   = 3'd3;
    localparam logic [2:0] MODE_FAULT = 3'd4;

    // Error codes
    localparam logic [2:0] ERR_NONE = 3'd0;
    localparam logic [2:0] ERR_HB   = 3'd1;
    localparam logic [2:0] ERR_LMIN = 3'd2;
    localparam logic [2:0] ERR_LMAX = 3'd3;
    localparam logic [2:0] ERR_HOME = 3'd4;

    // Homing phases
    localparam logic [1:0] PH_FAST = 2'd0;
    localparam logic [1:0] PH_BACK = 2'd1;
    localparam logic [1:0] PH_SLOW = 2'd2;

    // Step modes
    localparam logic [1:0] STEP_NONE  = 2'd0;
    localparam logic [1:0] STEP_ACCEL = 2'd1;
    localparam logic [1:0] STEP_CONST = 2'd2;

    // Event opcodes
    localparam logic [2:0] OP_MOVE   = 3'd0;
    localparam logic [2:0] OP_HOME   = 3'd1;
    localparam logic [2:0] OP_JOG    = 3'd2;
    localparam logic [2:0] OP_STEP   = 3'd3;
    localparam logic [2:0] OP_SWITCH = 3'd4;
    localparam logic [2:0] OP_BEAT   = 3'd5;
    localparam logic [2:0] OP_CHECK  = 3'd6;

    // Register indexes
    localparam logic [1:0] REG_HB_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_MAX_SPEED  = 2'd1;
    localparam logic [1:0] REG_BACKOFF    = 2'd2;

    // Register reset values
    localparam logic [15:0] HB_TIMEOUT_RST = 16'd0;
    localparam logic [15:0] MAX_SPEED_RST  = 16'd1000;
    localparam logic [15:0] BACKOFF_RST    = 16'd200;
    localparam logic [8:0]  CREEP_RST      = 9'd80;

    // Creep speed: floor(2*max_speed/25) as (x * RECIP) >> RECIP_SHIFT, x < 2^17
    localparam int          RECIP_SHIFT = 22;
    localparam logic [17:0] RECIP_25    = 18'd167773;
    localparam logic [8:0]  CREEP_MIN   = 9'd30;
    localparam logic [8:0]  CREEP_MAX   = 9'd400;
    localparam logic [16:0] CREEP_MOVE  = 17'd50000;

    typedef struct packed {
        logic [2:0]  op;
        logic        seek_negative;
        logic [31:0] now_ms;
        logic        at_target;
        logic        limit_min;
        logic        limit_max;
    } in_item_t;

    typedef struct packed {
        logic [8:0]         creep_speed;
        logic               speed_valid;
        logic               zero_position;
        logic signed [16:0] move_distance;
        logic               move_valid;
        logic               stop_motor;
        logic [1:0]         step_mode;
        logic [1:0]         phase;
        logic [2:0]         error_code;
        logic [2:0]         mode;
    } out_item_t;

    typedef struct packed {
        logic [15:0] heartbeat_timeout_ms;
        logic [15:0] backoff_steps;
        logic [8:0]  creep_speed;
    } cfg_t;

endpackage

`default_nettype wire

[rtl/stepper_axis_supervisor_core.sv]
// Throughput: one item per cycle; the input register feeds the event logic, which
// writes the result register, and both advance whenever the result slot is free.
// Reset (rst_n low, asynchronous): axis idle, phase fast, no heartbeat, no error,
// registers back to their defaults, both pipeline registers empty.
`default_nettype none

module stepper_axis_supervisor_core
    import sas_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // event items
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // op, seek_negative, now_ms, at_target,
                                            // limit_min, limit_max
    // result items
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,  // mode, error_code, phase, step_mode,
                                            // stop_motor, move_valid, move_distance,
                                            // zero_position, speed_valid, creep_speed
    // register writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    logic      advance;
    cfg_t      cfg;
    out_item_t res;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign cfg_ready     = 1'b1;

    sas_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    sas_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .item  (in_item_reg),
        .cfg   (cfg),
        .res   (res)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_item_reg.op            <= s_axis_tdata[2:0];
            in_item_reg.seek_negative <= s_axis_tdata[3];
            in_item_reg.now_ms        <= s_axis_tdata[35:4];
            in_item_reg.at_target     <= s_axis_tdata[36];
            in_item_reg.limit_min     <= s_axis_tdata[37];
            in_item_reg.limit_max     <= s_axis_tdata[38];
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_item_reg <= res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_item_reg;

endmodule

`default_nettype wire

[rtl/sas_cfg.sv]
`default_nettype none

module sas_cfg
    import sas_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        wr_en,
    input  wire logic [1:0]  wr_index,
    input  wire logic [15:0] wr_data,
    output cfg_t             cfg
);

    logic [15:0] hb_timeout_reg;
    logic [15:0] backoff_reg;
    logic [8:0]  creep_reg;
    logic [34:0] creep_prod;
    logic [12:0] creep_quot;
    logic [8:0]  creep_next;

    // Creep speed from the written max speed, clamped; stored so the event path stays short
    always_comb
    begin
        creep_prod = {1'b0, wr_data, 1'b0} * {17'd0, RECIP_25};
        creep_quot = creep_prod[34:RECIP_SHIFT];
        if (creep_quot < 13'(CREEP_MIN))
            creep_next = CREEP_MIN;
        else if (creep_quot > 13'(CREEP_MAX))
            creep_next = CREEP_MAX;
        else
            creep_next = creep_quot[8:0];
    end

    // Register writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hb_timeout_reg <= HB_TIMEOUT_RST;
            backoff_reg    <= BACKOFF_RST;
            creep_reg      <= CREEP_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_HB_TIMEOUT: hb_timeout_reg <= wr_data;
                REG_MAX_SPEED:  creep_reg      <= creep_next;
                REG_BACKOFF:    backoff_reg    <= wr_data;
                default:        ;
            endcase
        end
    end

    assign cfg.heartbeat_timeout_ms = hb_timeout_reg;
    assign cfg.backoff_steps        = backoff_reg;
    assign cfg.creep_speed          = creep_reg;

endmodule

`default_nettype wire

[rtl/sas_ctrl.sv]
`default_nettype none

module sas_ctrl
    import sas_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      fire,
    input  in_item_t       item,
    input  cfg_t           cfg,
    output out_item_t      res
);

    logic [2:0]  mode_reg,  mode_next;
    logic [1:0]  phase_reg, phase_next;
    logic        seek_neg_reg, seek_neg_next;
    logic [31:0] beat_reg,  beat_next;
    logic [2:0]  err_reg,   err_next;

    logic [1:0]         step_mode;
    logic               stop_motor;
    logic               move_valid;
    logic signed [16:0] move_distance;
    logic               zero_position;
    logic               speed_valid;
    logic [8:0]         creep_speed;
    logic [31:0]        silence;
    logic               limit_hit;

    assign silence   = item.now_ms - beat_reg;
    assign limit_hit = item.limit_min | item.limit_max;

    // Event decode and next state
    always_comb
    begin
        mode_next     = mode_reg;
        phase_next    = phase_reg;
        seek_neg_next = seek_neg_reg;
        beat_next     = beat_reg;
        err_next      = err_reg;
        step_mode     = STEP_NONE;
        stop_motor    = 1'b0;
        move_valid    = 1'b0;
        move_distance = '0;
        zero_position = 1'b0;
        speed_valid   = 1'b0;
        creep_speed   = '0;

        case (item.op)
            OP_MOVE:
            begin
                mode_next = MODE_RUN;
                err_next  = ERR_NONE;
            end
            OP_HOME:
            begin
                mode_next     = MODE_HOME;
                phase_next    = PH_FAST;
                seek_neg_next = item.seek_negative;
                err_next      = ERR_NONE;
            end
            OP_JOG:
            begin
                mode_next = MODE_JOG;
                err_next  = ERR_NONE;
            end
            OP_STEP:
            begin
                if (mode_reg == MODE_RUN || mode_reg == MODE_HOME || mode_reg == MODE_JOG)
                begin
                    step_mode = (mode_reg == MODE_JOG) ? STEP_CONST : STEP_ACCEL;
                    if (limit_hit)
                    begin
                        // minimum limit takes priority
                        stop_motor = 1'b1;
                        mode_next  = MODE_FAULT;
                        err_next   = item.limit_min ? ERR_LMIN : ERR_LMAX;
                    end
                    else if (mode_reg == MODE_HOME && phase_reg == PH_BACK && item.at_target)
                    begin
                        // back-off done: creep back toward the switch
                        speed_valid   = 1'b1;
                        creep_speed   = cfg.creep_speed;
                        move_valid    = 1'b1;
                        move_distance = seek_neg_reg ? -$signed(CREEP_MOVE)
                                                     : $signed(CREEP_MOVE);
                        phase_next    = PH_SLOW;
                    end
                    else if (item.at_target && mode_reg == MODE_RUN)
                    begin
                        mode_next = MODE_IDLE;
                        err_next  = ERR_NONE;
                    end
                    else if (item.at_target && mode_reg == MODE_HOME && phase_reg == PH_FAST)
                    begin
                        // fast seek ran out without finding the switch
                        mode_next  = MODE_FAULT;
                        err_next   = ERR_HOME;
                        phase_next = PH_FAST;
                    end
                end
            end
            OP_SWITCH:
            begin
                if (mode_reg == MODE_HOME)
                begin
                    if (phase_reg == PH_FAST)
                    begin
                        stop_motor    = 1'b1;
                        move_valid    = 1'b1;
                        move_distance = seek_neg_reg ? $signed({1'b0, cfg.backoff_steps})
                                                     : -$signed({1'b0, cfg.backoff_steps});
                        phase_next    = PH_BACK;
                    end
                    else if (phase_reg == PH_SLOW)
                    begin
                        stop_motor    = 1'b1;
                        zero_position = 1'b1;
                        mode_next     = MODE_IDLE;
                        err_next      = ERR_NONE;
                        phase_next    = PH_FAST;
                    end
                end
            end
            OP_BEAT:
            begin
                beat_next = item.now_ms;
            end
            OP_CHECK:
            begin
                if (cfg.heartbeat_timeout_ms != '0 && mode_reg != MODE_FAULT &&
                    beat_reg != '0 && silence > {16'd0, cfg.heartbeat_timeout_ms})
                begin
                    stop_motor = 1'b1;
                    mode_next  = MODE_FAULT;
                    err_next   = ERR_HB;
                    beat_next  = '0;
                end
            end
            default: ;
        endcase
    end

    // Supervisor state, updated once per processed item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_IDLE;
            phase_reg    <= PH_FAST;
            seek_neg_reg <= 1'b0;
            beat_reg     <= '0;
            err_reg      <= ERR_NONE;
        end
        else if (fire)
        begin
            mode_reg     <= mode_next;
            phase_reg    <= phase_next;
            seek_neg_reg <= seek_neg_next;
            beat_reg     <= beat_next;
            err_reg      <= err_next;
        end
    end

    assign res.mode          = mode_next;
    assign res.error_code    = err_next;
    assign res.phase         = phase_next;
    assign res.step_mode     = step_mode;
    assign res.stop_motor    = stop_motor;
    assign res.move_valid    = move_valid;
    assign res.move_distance = move_distance;
    assign res.zero_position = zero_position;
    assign res.speed_valid   = speed_valid;
    assign res.creep_speed   = creep_speed;

endmodule

`default_nettype wire

[test/tb_stepper_axis_supervisor_core.sv]
`timescale 1ns / 100ps

module tb_stepper_axis_supervisor_core;

    import sas_pkg::*;

    // op value with no meaning; the block must leave its state alone
    localparam logic [2:0] OP_UNUSED = 3'd7;
    localparam int PHASE_ITEMS = 225;
    localparam int HOLD_CYCLES = 80;

    // Expected command results for one axis, worked out per accepted event
    class axis_command_board;
        // register copies
        logic [15:0] hb_timeout;
        logic [15:0] max_speed;
        logic [15:0] backoff;
        // axis state copies
        logic [2:0]  axis_mode;
        logic [1:0]  home_phase;
        logic        seek_neg;
        logic [31:0] last_beat;
        logic [2:0]  last_err;

        out_item_t   pending_cmds[$];
        int          mismatch_count;
        int          results_checked;

        function new();
            hb_timeout      = HB_TIMEOUT_RST;
            max_speed       = MAX_SPEED_RST;
            backoff         = BACKOFF_RST;
            axis_mode       = MODE_IDLE;
            home_phase      = PH_FAST;
            seek_neg        = 1'b0;
            last_beat       = '0;
            last_err        = ERR_NONE;
            mismatch_count  = 0;
            results_checked = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] val);
            case (idx)
                REG_HB_TIMEOUT: hb_timeout = val;
                REG_MAX_SPEED:  max_speed = val;
                REG_BACKOFF:    backoff = val;
                default: ;
            endcase
        endfunction

        // floor(2*max/25), clamped
        function logic [8:0] creep_speed();
            int unsigned c;
            c = (int'(max_speed) * 2) / 25;
            if (c < CREEP_MIN)
                c = CREEP_MIN;
            if (c > CREEP_MAX)
                c = CREEP_MAX;
            return c[8:0];
        endfunction

        function logic [16:0] signed_steps(logic [16:0] mag, logic neg);
            return neg ? (17'd0 - mag) : mag;
        endfunction

        // min switch wins over max
        function logic trip_limits(logic lmin, logic lmax);
            if (lmin)
            begin
                axis_mode = MODE_FAULT;
                last_err  = ERR_LMIN;
                return 1'b1;
            end
            if (lmax)
            begin
                axis_mode = MODE_FAULT;
                last_err  = ERR_LMAX;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_event(logic [39:0] d);
            logic [2:0]  op;
            logic        seek_in;
            logic [31:0] now;
            logic [31:0] gap;
            logic        at_tgt;
            logic        lmin;
            logic        lmax;
            out_item_t   r;
            op      = d[2:0];
            seek_in = d[3];
            now     = d[35:4];
            at_tgt  = d[36];
            lmin    = d[37];
            lmax    = d[38];
            r       = '0;
            case (op)
                OP_MOVE:
                begin
                    axis_mode = MODE_RUN;
                    last_err  = ERR_NONE;
                end
                OP_HOME:
                begin
                    axis_mode  = MODE_HOME;
                    home_phase = PH_FAST;
                    seek_neg   = seek_in;
                    last_err   = ERR_NONE;
                end
                OP_JOG:
                begin
                    axis_mode = MODE_JOG;
                    last_err  = ERR_NONE;
                end
                OP_STEP:
                begin
                    if (axis_mode == MODE_RUN || axis_mode == MODE_HOME)
                    begin
                        r.step_mode  = STEP_ACCEL;
                        r.stop_motor = trip_limits(lmin, lmax);
                        if (!r.stop_motor)
                        begin
                            if (axis_mode == MODE_HOME && home_phase == PH_BACK && at_tgt)
                            begin
                                // back-off done: creep back toward the switch
                                r.speed_valid   = 1'b1;
                                r.creep_speed   = creep_speed();
                                r.move_valid    = 1'b1;
                                r.move_distance = signed_steps(CREEP_MOVE, seek_neg);
                                home_phase      = PH_SLOW;
                            end
                            else if (at_tgt && axis_mode == MODE_RUN)
                            begin
                                axis_mode = MODE_IDLE;
                                last_err  = ERR_NONE;
                            end
                            else if (at_tgt && axis_mode == MODE_HOME && home_phase == PH_FAST)
                            begin
                                // reached the seek target without seeing the switch
                                axis_mode  = MODE_FAULT;
                                last_err   = ERR_HOME;
                                home_phase = PH_FAST;
                            end
                        end
                    end
                    else if (axis_mode == MODE_JOG)
                    begin
                        r.step_mode  = STEP_CONST;
                        r.stop_motor = trip_limits(lmin, lmax);
                    end
                end
                OP_SWITCH:
                begin
                    if (axis_mode == MODE_HOME && home_phase == PH_FAST)
                    begin
                        r.stop_motor    = 1'b1;
                        r.move_valid    = 1'b1;
                        r.move_distance = signed_steps({1'b0, backoff}, !seek_neg);
                        home_phase      = PH_BACK;
                    end
                    else if (axis_mode == MODE_HOME && home_phase == PH_SLOW)
                    begin
                        r.stop_motor    = 1'b1;
                        r.zero_position = 1'b1;
                        axis_mode       = MODE_IDLE;
                        last_err        = ERR_NONE;
                        home_phase      = PH_FAST;
                    end
                end
                OP_BEAT:
                    last_beat = now;
                OP_CHECK:
                begin
                    gap = now - last_beat;
                    if (hb_timeout != 0 && axis_mode != MODE_FAULT && last_beat != 0 &&
                        gap > {16'd0, hb_timeout})
                    begin
                        r.stop_motor = 1'b1;
                        axis_mode    = MODE_FAULT;
                        last_err     = ERR_HB;
                        last_beat    = '0;
                    end
                end
                default: ;
            endcase
            r.mode       = axis_mode;
            r.error_code = last_err;
            r.phase      = home_phase;
            pending_cmds.push_back(r);
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                mismatch_count++;
                if (mismatch_count <= 200)
                    $display("%0t ns: %s mismatch, expected %h, actual %h",
                             $time, field, want, got);
            end
        endfunction

        function void check_result(logic [39:0] d);
            out_item_t got;
            out_item_t want;
            got = out_item_t'(d);
            if (pending_cmds.size() == 0)
            begin
                mismatch_count++;
                $display("%0t ns: result %h with nothing expected", $time, d);
                return;
            end
            want = pending_cmds.pop_front();
            results_checked++;
            compare_field("mode", want.mode, got.mode);
            compare_field("error_code", want.error_code, got.error_code);
            compare_field("phase", want.phase, got.phase);
            compare_field("step_mode", want.step_mode, got.step_mode);
            compare_field("stop_motor", want.stop_motor, got.stop_motor);
            compare_field("move_valid", want.move_valid, got.move_valid);
            compare_field("move_distance", want.move_distance, got.move_distance);
            compare_field("zero_position", want.zero_position, got.zero_position);
            compare_field("speed_valid", want.speed_valid, got.speed_valid);
            compare_field("creep_speed", want.creep_speed, got.creep_speed);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // op, seek_negative, now_ms, at_target, limit_min, limit_max
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // mode, error_code, phase, step_mode, stop_motor, move_valid,
                                 // move_distance, zero_position, speed_valid, creep_speed
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    axis_command_board board = new();

    int          sender_idle_pct;
    int          receiver_stall_pct;
    bit          hold_request;
    int          hold_left;
    int          items_sent;
    int          cur_timeout;
    logic [31:0] clock_ms;

    stepper_axis_supervisor_core dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // result side: random stalls, or a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    // predict on accepted events, check accepted results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                board.note_event(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                board.check_result(m_axis_tdata);
        end
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("timeout with %0d results outstanding", board.pending_cmds.size());
        $display("status: fail");
        $finish;
    end

    function automatic logic rnd_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    // millisecond time that moves forward a little per event
    function automatic logic [31:0] tick();
        clock_ms = clock_ms + $urandom_range(0, 25);
        return clock_ms;
    endfunction

    task automatic send_event(logic [2:0] op, logic seek, logic [31:0] now,
                              logic at_tgt, logic lmin, logic lmax);
        @(negedge clk);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, lmax, lmin, at_tgt, now, seek, op};
        do
            @(posedge clk);
        while (!s_axis_tready);
        items_sent++;
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (board.pending_cmds.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.write_reg(idx, val);
        if (idx == REG_HB_TIMEOUT)
            cur_timeout = int'(val);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_all_regs(logic [15:0] timeout, logic [15:0] speed, logic [15:0] steps);
        write_reg(REG_HB_TIMEOUT, timeout);
        write_reg(REG_MAX_SPEED, speed);
        write_reg(REG_BACKOFF, steps);
    endtask

    // run step with rare limit trips, sometimes after a heartbeat
    task automatic run_step(logic at_tgt);
        logic lmin;
        logic lmax;
        lmin = ($urandom_range(0, 99) < 3);
        lmax = ($urandom_range(0, 99) < 3);
        if ($urandom_range(0, 99) < 8)
            send_event(OP_BEAT, rnd_bit(), tick(), rnd_bit(), rnd_bit(), rnd_bit());
        send_event(OP_STEP, rnd_bit(), tick(), at_tgt, lmin, lmax);
    endtask

    // full homing: fast seek, switch, back-off, creep, switch
    task automatic run_homing();
        int n;
        send_event(OP_HOME, rnd_bit(), tick(), rnd_bit(), rnd_bit(), rnd_bit());
        n = $urandom_range(0, 4);
        repeat (n) run_step($urandom_range(0, 99) < 4);
        send_event(OP_SWITCH, rnd_bit(), tick(), rnd_bit(), rnd_bit(), rnd_bit());
        n = $urandom_range(0, 3);
        repeat (n) run_step(1'b0);
        run_step(1'b1);
        n = $urandom_range(0, 3);
        repeat (n) run_step(rnd_bit());
        send_event(OP_SWITCH, rnd_bit(), tick(), rnd_bit(), rnd_bit(), rnd_bit());
    endtask

    task automatic run_move();
        int n;
        send_event(OP_MOVE, rnd_bit(), tick(), rnd_bit(), rnd_bit(), rnd_bit());
        n = $urandom_range(0, 5);
        repeat (n) run_step(1'b0);
        run_step($urandom_range(0, 99) < 80);
    endtask

    task automatic run_jog();
        int n;
        send_event(OP_JOG, rnd_bit(), tick(), rnd_bit(), rnd_bit(), rnd_bit());
        n = $urandom_range(1, 6);
        repeat (n) run_step(rnd_bit());
    endtask

    // heartbeat, then supervision checks on both sides of the timeout
    task automatic run_heartbeat();
        logic [31:0] beat_ms;
        logic [31:0] probe_ms;
        int n;
        beat_ms = ($urandom_range(0, 9) == 0) ? 32'd0 : tick();
        probe_ms = beat_ms;
        send_event(OP_BEAT, rnd_bit(), beat_ms, rnd_bit(), rnd_bit(), rnd_bit());
        n = $urandom_range(1, 3);
        repeat (n)
        begin
            probe_ms = beat_ms + $urandom_range(0, 2 * cur_timeout + 2);
            send_event(OP_CHECK, rnd_bit(), probe_ms, rnd_bit(), rnd_bit(), rnd_bit());
        end
        clock_ms = probe_ms;
    endtask

    task automatic run_noise();
        int n;
        n = $urandom_range(1, 4);
        repeat (n)
            send_event(3'($urandom_range(0, 7)), rnd_bit(), $urandom, rnd_bit(), rnd_bit(),
                       rnd_bit());
    endtask

    // random event mix; a long result hold-off halfway, a full drain later
    task automatic run_random(int count);
        int stop_at;
        int pick;
        bit held;
        bit drained;
        stop_at = items_sent + count;
        held    = 1'b0;
        drained = 1'b0;
        while (items_sent < stop_at)
        begin
            if (!held && items_sent >= stop_at - count / 2)
            begin
                held         = 1'b1;
                hold_request = 1'b1;
            end
            if (!drained && items_sent >= stop_at - count / 4)
            begin
                drained = 1'b1;
                drain();
            end
            pick = $urandom_range(0, 99);
            if (pick < 35)
                run_homing();
            else if (pick < 55)
                run_move();
            else if (pick < 65)
                run_jog();
            else if (pick < 85)
                run_heartbeat();
            else
                run_noise();
        end
    endtask

    initial
    begin
        logic [15:0] timeout_tbl[6];
        logic [15:0] speed_tbl[6];
        logic [15:0] backoff_tbl[6];
        int p;

        rst_n              = 1'b0;
        s_axis_tvalid      = 1'b0;
        s_axis_tdata       = '0;
        m_axis_tready      = 1'b0;
        cfg_valid          = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        hold_request       = 1'b0;
        hold_left          = 0;
        items_sent         = 0;
        cur_timeout        = int'(HB_TIMEOUT_RST);
        sender_idle_pct    = 16;
        receiver_stall_pct = 16;
        clock_ms           = $urandom;

        timeout_tbl = '{16'd300, 16'd65535, 16'd1, 16'd0, 16'd0, 16'd40};
        speed_tbl   = '{16'd1000, 16'd65535, 16'd1, 16'd0, 16'd0, 16'd375};
        backoff_tbl = '{16'd200, 16'd65535, 16'd1, 16'd0, 16'd0, 16'd16};
        timeout_tbl[4] = 16'($urandom_range(1, 2000));
        speed_tbl[4]   = 16'($urandom_range(1, 65535));
        backoff_tbl[4] = 16'($urandom_range(1, 500));

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset registers, every op but check, limits, homing path
        send_event(OP_STEP, 1'b1, tick(), 1'b1, 1'b1, 1'b1);    // step while idle
        send_event(OP_SWITCH, 1'b0, tick(), 1'b0, 1'b0, 1'b0);  // switch outside homing
        send_event(OP_UNUSED, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
        send_event(OP_BEAT, 1'b0, 32'd0, 1'b0, 1'b0, 1'b0);     // beat at zero reads as none
        send_event(OP_MOVE, 1'b0, tick(), 1'b0, 1'b0, 1'b0);
        send_event(OP_STEP, 1'b0, tick(), 1'b1, 1'b1, 1'b1);    // both limits, min wins
        send_event(OP_STEP, 1'b0, tick(), 1'b1, 1'b0, 1'b0);    // step while faulted
        send_event(OP_MOVE, 1'b0, tick(), 1'b0, 1'b0, 1'b0);
        send_event(OP_STEP, 1'b0, tick(), 1'b1, 1'b0, 1'b0);    // move done
        send_event(OP_JOG, 1'b0, tick(), 1'b0, 1'b0, 1'b0);
        send_event(OP_STEP, 1'b0, tick(), 1'b0, 1'b0, 1'b1);    // jog hits max limit
        send_event(OP_HOME, 1'b1, tick(), 1'b0, 1'b0, 1'b0);
        send_event(OP_STEP, 1'b0, tick(), 1'b1, 1'b0, 1'b0);    // seek ends, no switch
        send_event(OP_HOME, 1'b0, tick(), 1'b0, 1'b0, 1'b0);
        send_event(OP_STEP, 1'b0, tick(), 1'b0, 1'b0, 1'b0);
        send_event(OP_SWITCH, 1'b0, tick(), 1'b0, 1'b0, 1'b0);  // fast seek hit
        send_event(OP_SWITCH, 1'b0, tick(), 1'b0, 1'b0, 1'b0);  // ignored during back-off
        send_event(OP_STEP, 1'b0, tick(), 1'b1, 1'b0, 1'b0);    // back-off done, creep
        send_event(OP_STEP, 1'b0, tick(), 1'b1, 1'b0, 1'b0);    // slow at target, no switch
        send_event(OP_SWITCH, 1'b0, tick(), 1'b0, 1'b0, 1'b0);  // slow hit, zero
        drain();

        // directed: heartbeat timing across the wrap, top register values
        write_all_regs(16'd100, 16'd65535, 16'd65535);
        send_event(OP_BEAT, 1'b0, 32'hFFFF_FFC0, 1'b0, 1'b0, 1'b0);
        send_event(OP_CHECK, 1'b0, 32'h0000_0010, 1'b0, 1'b0, 1'b0);  // within timeout
        send_event(OP_CHECK, 1'b0, 32'h0000_0040, 1'b0, 1'b0, 1'b0);  // past timeout
        send_event(OP_HOME, 1'b1, tick(), 1'b0, 1'b0, 1'b0);
        send_event(OP_SWITCH, 1'b0, tick(), 1'b0, 1'b0, 1'b0);
        send_event(OP_STEP, 1'b0, tick(), 1'b1, 1'b0, 1'b0);
        send_event(OP_BEAT, 1'b0, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
        send_event(OP_CHECK, 1'b0, 32'd0, 1'b0, 1'b0, 1'b0);
        drain();

        // random phases over register settings and handshake patterns
        for (p = 0; p < 6; p++)
        begin
            write_all_regs(timeout_tbl[p], speed_tbl[p], backoff_tbl[p]);
            case (p % 4)
                0:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct    = 87;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 87;
                end
                default:
                begin
                    sender_idle_pct    = 16;
                    receiver_stall_pct = 16;
                end
            endcase
            run_random(PHASE_ITEMS);
            drain();
        end

        $display("%0d events over eight register settings, all ops, homing, limits and heartbeats",
                 items_sent);
        $display("%0d results compared under four handshake patterns, %0d field errors",
                 board.results_checked, board.mismatch_count);
        if (board.mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
